/* hw/rtl/gra_pkg.sv */
// Shared group running aggregator definitions: mode codes, data widths and
// divider structs. No dependencies; imported by every module of the block.
`default_nettype none

package gra_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 64;
    localparam int COUNT_W    = 32;
    localparam int MODE_W     = 4;

    // Aggregate mode codes
    localparam logic [MODE_W-1:0] MODE_COUNT  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUM    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MEAN   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MIN    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MAX    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ABSMIN = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ABSMAX = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_LAST   = 4'd8;

    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_SUM;

    // Divider control and status between the sequencer and the divide unit
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic done;
    } div_sts_t;

endpackage : gra_pkg

`default_nettype wire

/* hw/rtl/group_running_aggregator_unit.sv */
// Top level of the group running aggregator: handshakes, sequencer, the
// shared 65-bit add/compare unit and result register. Uses gra_pkg, gra_div.
`default_nettype none

//  Channel   Direction  Ports                               Contents
//  -------   ---------  ----------------------------------  ---------------------------
//  input     in         s_tvalid/s_tready/s_tdata/s_tlast   sample; tlast = end_of_group
//  result    out        m_tvalid/m_tready/m_tdata/m_tuser   aggregate, item_count; overflow
//  config    in         cfg_wr_en/cfg_wr_data               aggregate_mode, no read-back
//
// Each sample is accepted, then makes one pass through the shared add/compare
// unit. A group end in mean mode then loads the divider, runs the bit-serial
// divider and sign-fixes the quotient into the result register. Reset puts
// the mode at sum and clears the group state. Input is taken only when the
// sequencer is idle and the result register is empty or being emptied in
// that cycle, so a result stalled on the output holds off the next
// transaction.

module group_running_aggregator_unit
    import gra_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,   // [31:0] sample
    input  wire logic                s_tlast,   // end_of_group

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [95:0]              m_tdata,   // [63:0] aggregate, [95:64] item_count
    output logic [0:0]               m_tuser,   // [0] overflow

    input  wire logic                cfg_wr_en,
    input  wire logic [MODE_W-1:0]   cfg_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CALC  = 4'b0010,
        ST_DIVLD = 4'b0100,
        ST_DIVW  = 4'b1000
    } state_t;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // registers
    state_t              state_reg,   state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [MODE_W-1:0]   op_mode_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic                last_reg;
    logic [ACC_W-1:0]    rv_reg,      rv_next;
    logic [COUNT_W-1:0]  cnt_reg,     cnt_next;
    logic                start_reg,   start_next;
    logic                sat_reg,     sat_next;
    logic                out_vld_reg, out_vld_next;
    logic [ACC_W-1:0]    out_agg_reg, out_agg_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic                out_ovf_reg, out_ovf_next;

    // shared unit and helpers
    logic [ACC_W-1:0]    s64;
    logic [ACC_W-1:0]    mag_s;
    logic [ACC_W-1:0]    mag_rv;
    logic [ACC_W:0]      op_a;
    logic [ACC_W:0]      op_b;
    logic                op_sub;
    logic [ACC_W:0]      alu;
    logic                alu_neg;
    logic                alu_nz;
    logic                seed;
    logic [ACC_W-1:0]    rv_calc;
    logic                sum_ovf;
    logic [ACC_W-1:0]    agg_calc;

    logic                in_xfer;
    logic                out_xfer;

    div_ctl_t            div_ctl;
    div_sts_t            div_sts;
    logic [ACC_W-1:0]    div_q;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = out_vld_reg && m_tready;
    assign s_tready = (state_reg == ST_IDLE) && (!out_vld_reg || m_tready);

    // Select operands for the one add/subtract unit by mode
    always_comb
    begin
        s64    = {{(ACC_W-SAMPLE_W){smp_reg[SAMPLE_W-1]}}, smp_reg};
        mag_s  = s64[ACC_W-1] ? (~s64 + 1'b1) : s64;
        mag_rv = rv_reg[ACC_W-1] ? (~rv_reg + 1'b1) : rv_reg;
        seed   = start_reg && ((op_mode_reg == MODE_MIN) || (op_mode_reg == MODE_MAX) ||
                               (op_mode_reg == MODE_ABSMIN) || (op_mode_reg == MODE_ABSMAX));

        op_a   = {s64[ACC_W-1], s64};
        op_b   = {rv_reg[ACC_W-1], rv_reg};
        op_sub = 1'b1;
        case (op_mode_reg)
            MODE_SUM, MODE_MEAN:
            begin
                op_a   = {rv_reg[ACC_W-1], rv_reg};
                op_b   = {s64[ACC_W-1], s64};
                op_sub = 1'b0;
            end
            MODE_ABSMIN, MODE_ABSMAX:
            begin
                op_a = {1'b0, mag_s};
                op_b = {1'b0, mag_rv};
            end
            default:
            begin
                op_sub = 1'b1;
            end
        endcase

        alu     = op_sub ? (op_a - op_b) : (op_a + op_b);
        alu_neg = alu[ACC_W];
        alu_nz  = |alu;
        sum_ovf = alu[ACC_W] != alu[ACC_W-1];

        rv_calc = rv_reg;
        case (op_mode_reg)
            MODE_SUM, MODE_MEAN:
            begin
                if (sum_ovf)
                    rv_calc = alu[ACC_W] ? ACC_MIN : ACC_MAX;
                else
                    rv_calc = alu[ACC_W-1:0];
            end
            MODE_MIN, MODE_ABSMIN:
            begin
                if (seed || alu_neg)
                    rv_calc = s64;
            end
            MODE_MAX, MODE_ABSMAX:
            begin
                if (seed || (!alu_neg && alu_nz))
                    rv_calc = s64;
            end
            MODE_FIRST:
            begin
                if (start_reg)
                    rv_calc = s64;
            end
            MODE_LAST:
            begin
                rv_calc = s64;
            end
            default:
            begin
                rv_calc = rv_reg;
            end
        endcase
    end

    // Sequencer and group state
    always_comb
    begin
        state_next   = state_reg;
        rv_next      = rv_reg;
        cnt_next     = cnt_reg;
        start_next   = start_reg;
        sat_next     = sat_reg;
        out_vld_next = out_xfer ? 1'b0 : out_vld_reg;
        out_agg_next = out_agg_reg;
        out_cnt_next = out_cnt_reg;
        out_ovf_next = out_ovf_reg;
        div_ctl      = '0;
        agg_calc     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_CALC;
            end

            ST_CALC:
            begin
                // saturating count, then the mode update
                if (cnt_reg == {COUNT_W{1'b1}})
                    cnt_next = cnt_reg;
                else
                    cnt_next = cnt_reg + 1'b1;
                sat_next   = sat_reg || (cnt_reg == {COUNT_W{1'b1}}) ||
                             (((op_mode_reg == MODE_SUM) || (op_mode_reg == MODE_MEAN))
                              && sum_ovf);
                rv_next    = rv_calc;
                start_next = 1'b0;

                case (op_mode_reg)
                    MODE_COUNT:
                        agg_calc = {{(ACC_W-COUNT_W){1'b0}}, cnt_next};
                    MODE_SUM, MODE_MIN, MODE_MAX, MODE_ABSMIN, MODE_ABSMAX,
                    MODE_FIRST, MODE_LAST:
                        agg_calc = rv_calc;
                    default:
                        agg_calc = '0;
                endcase

                if (!last_reg)
                    state_next = ST_IDLE;
                else if (op_mode_reg == MODE_MEAN)
                    state_next = ST_DIVLD;
                else
                begin
                    // emit and clear the group
                    out_vld_next = 1'b1;
                    out_agg_next = agg_calc;
                    out_cnt_next = cnt_next;
                    out_ovf_next = sat_next;
                    rv_next      = '0;
                    cnt_next     = '0;
                    start_next   = 1'b1;
                    sat_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            ST_DIVLD:
            begin
                div_ctl.start = 1'b1;
                state_next    = ST_DIVW;
            end

            ST_DIVW:
            begin
                if (div_sts.done)
                begin
                    out_vld_next = 1'b1;
                    out_agg_next = rv_reg[ACC_W-1] ? (~div_q + 1'b1) : div_q;
                    out_cnt_next = cnt_reg;
                    out_ovf_next = sat_reg;
                    rv_next      = '0;
                    cnt_next     = '0;
                    start_next   = 1'b1;
                    sat_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_RESET;
            rv_reg      <= '0;
            cnt_reg     <= '0;
            start_reg   <= 1'b1;
            sat_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rv_reg      <= rv_next;
            cnt_reg     <= cnt_next;
            start_reg   <= start_next;
            sat_reg     <= sat_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
        end
    end

    // Payload: hold the accepted transaction and the pending result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            smp_reg     <= s_tdata;
            last_reg    <= s_tlast;
            op_mode_reg <= mode_reg;
        end
        out_agg_reg <= out_agg_next;
        out_cnt_reg <= out_cnt_next;
        out_ovf_reg <= out_ovf_next;
    end

    gra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (mag_rv),
        .divisor  (cnt_reg),
        .sts      (div_sts),
        .quotient (div_q)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_cnt_reg, out_agg_reg};
    assign m_tuser  = out_ovf_reg;

endmodule : group_running_aggregator_unit

`default_nettype wire

/* hw/rtl/gra_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on gra_pkg for widths and the control/status structs.
`default_nettype none

module gra_div
    import gra_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire div_ctl_t           ctl,
    input  wire logic [ACC_W-1:0]   dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    output div_sts_t                sts,
    output logic [ACC_W-1:0]        quotient
);

    localparam int STEP_W = $clog2(ACC_W);

    logic [ACC_W-1:0]   quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] dvs_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [COUNT_W:0]   shifted;
    logic [COUNT_W+1:0] diff;
    logic               fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[ACC_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = ~diff[COUNT_W+1];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == {STEP_W{1'b1}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: shift in one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
            rem_reg <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
        end
    end

    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule : gra_div

`default_nettype wire

/* test/group_running_aggregator_checker.sv */
// Checker for the group running aggregator: watches the sample, result and
// mode-write channels, predicts each group result and compares it field by field.
// Depends on gra_pkg for the mode codes and the mode register width.
module group_running_aggregator_checker
    import gra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [95:0]       m_tdata,
    input  logic [0:0]        m_tuser,
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data,
    output int                fail_count,
    output int                pending,
    output int                result_count,
    output logic [15:0]       modes_hit
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] agg;
        logic [31:0] cnt;
        logic        ovf;
    } group_result_t;

    group_result_t group_results_q[$];

    // Shadow of the block's mode register and group state
    logic [MODE_W-1:0]  mode_q    = MODE_RESET;
    logic signed [63:0] acc       = '0;
    logic [31:0]        cnt       = '0;
    bit                 fresh     = 1'b1;
    bit                 sat       = 1'b0;

    function automatic logic [63:0] magnitude_of(input logic signed [63:0] x);
        return x[63] ? -x : x;
    endfunction

    function automatic void clear_group();
        acc   = '0;
        cnt   = '0;
        fresh = 1'b1;
        sat   = 1'b0;
    endfunction

    // Fold one accepted sample into the group; queue a result on a group end.
    function automatic void fold_sample(input logic [31:0] raw, input logic last);
        logic signed [63:0] s;
        logic signed [64:0] wide;
        logic [63:0]        q;
        group_result_t      r;
        s = {{32{raw[31]}}, raw};
        if (cnt == 32'hFFFF_FFFF)
            sat = 1'b1;
        else
            cnt = cnt + 32'd1;
        // Seed the order-based modes on the first sample of a group
        if (fresh)
        begin
            case (mode_q)
                MODE_MIN, MODE_MAX, MODE_ABSMIN, MODE_ABSMAX: acc = s;
                default: ;
            endcase
        end
        case (mode_q)
            MODE_SUM, MODE_MEAN:
            begin
                wide = {acc[63], acc} + {s[63], s};
                if (wide[64] != wide[63])
                begin
                    sat = 1'b1;
                    acc = wide[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                end
                else
                    acc = wide[63:0];
            end
            MODE_MIN:    if (s < acc) acc = s;
            MODE_MAX:    if (s > acc) acc = s;
            MODE_ABSMIN: if (magnitude_of(s) < magnitude_of(acc)) acc = s;
            MODE_ABSMAX: if (magnitude_of(s) > magnitude_of(acc)) acc = s;
            MODE_FIRST:  if (fresh) acc = s;
            MODE_LAST:   acc = s;
            default: ;
        endcase
        fresh = 1'b0;
        if (!last)
            return;
        case (mode_q)
            MODE_COUNT: r.agg = {32'b0, cnt};
            MODE_MEAN:
            begin
                q = magnitude_of(acc) / {32'b0, cnt};
                r.agg = acc[63] ? (64'd0 - q) : q;
            end
            MODE_SUM, MODE_MIN, MODE_MAX, MODE_ABSMIN, MODE_ABSMAX,
            MODE_FIRST, MODE_LAST: r.agg = acc;
            default: r.agg = '0;
        endcase
        r.cnt = cnt;
        r.ovf = sat;
        group_results_q.push_back(r);
        modes_hit[mode_q] = 1'b1;
        clear_group();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        group_result_t exp;
        if (!rst_n)
        begin
            mode_q = MODE_RESET;
            clear_group();
            group_results_q.delete();
            fail_count   = 0;
            result_count = 0;
            modes_hit    = '0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_q = cfg_wr_data;
            if (s_tvalid && s_tready)
                fold_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (group_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result, aggregate %h count %h overflow %b",
                             $time, m_tdata[63:0], m_tdata[95:64], m_tuser[0]);
                    fail_count++;
                end
                else
                begin
                    exp = group_results_q.pop_front();
                    if (m_tdata[63:0] !== exp.agg)
                    begin
                        $display("%0t: aggregate mismatch, expected %h, got %h",
                                 $time, exp.agg, m_tdata[63:0]);
                        fail_count++;
                    end
                    if (m_tdata[95:64] !== exp.cnt)
                    begin
                        $display("%0t: item_count mismatch, expected %h, got %h",
                                 $time, exp.cnt, m_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== exp.ovf)
                    begin
                        $display("%0t: overflow mismatch, expected %b, got %b",
                                 $time, exp.ovf, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
        pending = group_results_q.size();
    end

endmodule

/* test/tb_group_running_aggregator_unit.sv */
// Testbench top for the group running aggregator: clock, reset, sample and mode
// stimulus, result back-pressure and the verdict. Depends on gra_pkg, the block
// and group_running_aggregator_checker.
module tb_group_running_aggregator_unit;
    import gra_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_ITEMS = 1450;
    localparam int IDLE_WAIT    = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 4000;  // cycles with no transaction at all

    // Highest mode code; codes above MODE_LAST select no aggregate
    localparam logic [MODE_W-1:0] MODE_UNUSED_TOP = 4'd15;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;     // [31:0] sample
    logic              s_tlast;     // end_of_group
    logic              m_tvalid;
    logic              m_tready;
    logic [95:0]       m_tdata;     // [63:0] aggregate, [95:64] item_count
    logic [0:0]        m_tuser;     // [0] overflow
    logic              cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;

    int          fail_count;
    int          pending;
    int          result_count;
    logic [15:0] modes_hit;

    int sent        = 0;
    int mode_writes = 0;
    int stall_left  = 0;
    bit steady      = 1'b0;   // when set, neither side idles

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    group_running_aggregator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    group_running_aggregator_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .modes_hit    (modes_hit)
    );

    // Result back-pressure: mostly short stalls, now and then a long one.
    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (steady)
            m_tready <= 1'b1;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                m_tready <= 1'b1;
            else
            begin
                m_tready   <= 1'b0;
                stall_left <= (r < 92) ? $urandom_range(0, 3) : $urandom_range(10, 60);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Bias samples toward the extremes and toward small values that tie in magnitude.
    function automatic logic [31:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 50)
            return $urandom_range(0, 16) - 8;
        return $urandom;
    endfunction

    // Offer one sample after a random gap; hold it until the block takes it.
    task automatic push_sample(input logic [31:0] value, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // Hold the sender until every queued result has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Write the mode only while the block is idle.
    task automatic set_mode(input logic [MODE_W-1:0] mode);
        wait_drained();
        repeat (IDLE_WAIT) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
    endtask

    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(0, 19) < 18)
            return MODE_W'($urandom_range(MODE_COUNT, MODE_LAST));
        return MODE_W'($urandom_range(MODE_LAST + 1, MODE_UNUSED_TOP));
    endfunction

    initial
    begin : stimulus
        int len;
        int r;
        int groups;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        groups      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset mode is sum; push both rails through it
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b1);
        set_mode(MODE_COUNT);
        push_sample(32'h0000_0000, 1'b1);
        // Mean truncates toward zero: -7 + 2 over 2
        set_mode(MODE_MEAN);
        push_sample(32'hFFFF_FFF9, 1'b0);
        push_sample(32'h0000_0002, 1'b1);
        push_sample(32'h8000_0000, 1'b1);
        set_mode(MODE_MIN);
        push_sample(32'h0000_0005, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1);
        set_mode(MODE_MAX);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1);
        // Magnitude tie: keep the earlier of +3 and -3
        set_mode(MODE_ABSMIN);
        push_sample(32'h0000_0003, 1'b0);
        push_sample(32'hFFFF_FFFD, 1'b0);
        push_sample(32'h0000_0004, 1'b1);
        set_mode(MODE_ABSMAX);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1);
        set_mode(MODE_FIRST);
        push_sample(32'h0000_0011, 1'b0);
        push_sample(32'h0000_0022, 1'b1);
        set_mode(MODE_LAST);
        push_sample(32'h0000_0011, 1'b0);
        push_sample(32'h0000_0022, 1'b1);
        // Unused mode code: count still advances, aggregate reads zero
        set_mode(MODE_UNUSED_TOP);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'h0000_0002, 1'b1);
        // Switch mode inside a group: max seeds, sum then adds to it
        set_mode(MODE_MAX);
        push_sample(32'h0000_0009, 1'b0);
        set_mode(MODE_SUM);
        push_sample(32'h0000_0001, 1'b1);

        // Random groups with random content, mode changes and idle phases
        while (sent < TARGET_ITEMS)
        begin
            steady = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 3)
                set_mode(pick_mode());
            else if ($urandom_range(0, 19) == 0)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 4);
            else if (r < 95)
                len = $urandom_range(5, 16);
            else
                len = $urandom_range(17, 60);
            for (int i = 0; i < len; i++)
            begin
                if (i > 0 && $urandom_range(0, 99) < 4)
                    set_mode(pick_mode());
                push_sample(pick_sample(), i == len - 1);
            end
            groups++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples in %0d random groups plus directed cases, %0d mode writes.",
                 sent, groups, mode_writes);
        $display("Checked %0d group results; modes seen at group end: %b.",
                 result_count, modes_hit);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
